// File: rtl/utf8_to_utf16_transcoder_macros.svh
// ----------------------------------------------------------------------------
// utf8 to utf16 transcoder assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// condition holds at every edge
`define U8U16_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define U8U16_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// types and constants shared by the utf8 to utf16 transcoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [20:0] MAX_POINT   = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [15:0] HIGH_SURR   = 16'hD800;
  localparam logic [15:0] LOW_SURR    = 16'hDC00;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // kind of the closing part of a job
  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_UNIT = 2'd1;
  localparam logic [1:0] TAIL_PAIR = 2'd2;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } out_item_t;

  // work for one input byte: rep_cnt replacement units, then the tail
  typedef struct packed {
    logic [1:0]  rep_cnt;
    logic [1:0]  tail_kind;
    logic [15:0] unit_a;
    logic [15:0] unit_b;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// decodes utf8 bytes, tracks the open sequence and emits at most one job per accepted byte
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_front
  import u8u16_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_data,
  output logic          in_stall,
  input  wire logic     q_full,
  output logic          q_push,
  output job_t          q_data
);

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  expect_r, expect_nxt;
  logic [1:0]  held_r, held_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        eot;
  logic        run_lead;
  logic [20:0] cp;
  logic [20:0] v;
  logic [2:0]  held_sum;
  job_t        job;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_data.byte_in;
  assign eot      = in_data.end_of_text;
  assign cp       = {partial_r[14:0], b[5:0]};
  assign v        = cp - SUPP_BASE;

  always_comb begin
    partial_nxt   = partial_r;
    expect_nxt    = expect_r;
    held_nxt      = held_r;
    run_lead      = 1'b0;
    job.rep_cnt   = 2'd0;
    job.tail_kind = TAIL_NONE;
    job.unit_a    = REPLACEMENT;
    job.unit_b    = REPLACEMENT;

    if (expect_r == 2'd0) begin
      run_lead = 1'b1;
    end else if (b[7:6] == 2'b10) begin
      if (expect_r == 2'd1) begin
        partial_nxt = '0;
        expect_nxt  = 2'd0;
        held_nxt    = 2'd0;
        if (cp <= BMP_MAX) begin
          job.tail_kind = TAIL_UNIT;
          job.unit_a    = cp[15:0];
        end else if (cp <= MAX_POINT) begin
          job.tail_kind = TAIL_PAIR;
          job.unit_a    = HIGH_SURR + {6'd0, v[19:10]};
          job.unit_b    = LOW_SURR + {6'd0, v[9:0]};
        end else begin
          job.tail_kind = TAIL_UNIT;
        end
      end else if (eot) begin
        job.rep_cnt = held_r + 2'd1;
      end else begin
        partial_nxt = cp;
        expect_nxt  = expect_r - 2'd1;
        held_nxt    = held_r + 2'd1;
      end
    end else begin
      // broken sequence: one replacement per held byte, then decode as lead
      job.rep_cnt = held_r;
      partial_nxt = '0;
      expect_nxt  = 2'd0;
      held_nxt    = 2'd0;
      run_lead    = 1'b1;
    end

    if (run_lead) begin
      if (b[7] == 1'b0) begin
        job.tail_kind = TAIL_UNIT;
        job.unit_a    = {8'd0, b};
      end else if ((b[7:5] == 3'b110) || (b[7:4] == 4'b1110) || (b[7:3] == 5'b11110)) begin
        if (eot) begin
          job.tail_kind = TAIL_UNIT;
        end else begin
          held_nxt = 2'd1;
          if (b[7:5] == 3'b110) begin
            partial_nxt = {16'd0, b[4:0]};
            expect_nxt  = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            partial_nxt = {17'd0, b[3:0]};
            expect_nxt  = 2'd2;
          end else begin
            partial_nxt = {18'd0, b[2:0]};
            expect_nxt  = 2'd3;
          end
        end
      end else begin
        job.tail_kind = TAIL_UNIT;
      end
    end

    if (eot) begin
      partial_nxt = '0;
      expect_nxt  = 2'd0;
      held_nxt    = 2'd0;
    end
  end

  assign q_data = job;
  assign q_push = accept && ((job.rep_cnt != 2'd0) || (job.tail_kind != TAIL_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      expect_r  <= 2'd0;
      held_r    <= 2'd0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      expect_r  <= expect_nxt;
      held_r    <= held_nxt;
    end
  end

  assign held_sum = {1'b0, held_r} + {1'b0, expect_r};

  `U8U16_ASSERT_IMPL(a_idle_no_held, expect_r == 2'd0, held_r == 2'd0, "bytes held with no open sequence")
  `U8U16_ASSERT_IMPL(a_seq_len, expect_r != 2'd0, (held_sum >= 3'd2) && (held_sum <= 3'd4), "open sequence length out of range")
  `U8U16_ASSERT_NEXT(a_eot_closes, accept && eot, expect_r == 2'd0, "sequence left open after end of text")

endmodule

`default_nettype wire

// File: rtl/u8u16_fifo.sv
// ----------------------------------------------------------------------------
// u8u16_fifo
// short job queue between the decoder front and the unit emitter
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_fifo
  import u8u16_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_data,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      full,
  output logic      not_empty
);

  job_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// walks one job at a time and drives the utf16 units into the output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_back
  import u8u16_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_not_empty,
  input  wire job_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_data
);

  job_t       job_r;
  logic       job_valid_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  out_item_t  out_data_r;

  logic       out_free;
  logic       emit;
  logic       last;
  logic       load;
  logic [2:0] total;
  logic [15:0] unit;

  always_comb begin
    case (job_r.tail_kind)
      TAIL_UNIT: total = {1'b0, job_r.rep_cnt} + 3'd1;
      TAIL_PAIR: total = {1'b0, job_r.rep_cnt} + 3'd2;
      default:   total = {1'b0, job_r.rep_cnt};
    endcase
  end

  always_comb begin
    if (idx_r < job_r.rep_cnt) begin
      unit = REPLACEMENT;
    end else if (idx_r == job_r.rep_cnt) begin
      unit = job_r.unit_a;
    end else begin
      unit = job_r.unit_b;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = job_valid_r && out_free;
  assign last     = ({1'b0, idx_r} == (total - 3'd1));
  assign load     = q_not_empty && (!job_valid_r || (emit && last));
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        job_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (emit && last) begin
        job_valid_r <= 1'b0;
        idx_r       <= 2'd0;
      end else if (emit) begin
        idx_r <= idx_r + 2'd1;
      end
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_data;
    end
    if (emit) begin
      out_data_r.code_unit <= unit;
      out_data_r.last_unit <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `U8U16_ASSERT_IMPL(a_idx_bound, job_valid_r, {1'b0, idx_r} < total, "unit index past end of job")
  `U8U16_ASSERT_NEXT(a_job_stays, emit && !last, job_valid_r, "job dropped before its last unit")
  `U8U16_ASSERT_NEXT(a_job_done, emit && last && !load, !job_valid_r, "job kept after its last unit")

endmodule

`default_nettype wire

// File: rtl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// utf8 byte stream in, utf16 code units out, with replacement on bad input
//
//   channel  dir  payload                          handshake
//   in_      in   byte_in[7:0], end_of_text        in_valid / in_stall
//   out_     out  code_unit[15:0], last_unit       out_valid / out_stall
//
// one byte per cycle is taken while the job queue has room; each byte
// becomes zero to four units, emitted one per cycle by the back end while the output is not stalled
// the output register limits the rate to one unit per cycle, so bytes that
// give pairs or replacement bursts back up the four-entry job queue
// first unit passes through the job queue, the job register and then the output register
// synchronous reset clears the open sequence, the queue and the output
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  job_t q_wdata;
  job_t q_rdata;

  u8u16_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  u8u16_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  u8u16_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// File: sim/utf8_to_utf16_transcoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_tb
// feeds utf8 bytes through the transcoder and checks every utf16 code unit
// against a cycle-free predictor of the decoder; a directed pass covers
// boundary code points, surrogate pairs and every replacement rule, then
// random text mixes well-formed characters, noise bytes and broken sequences
// while both channels idle in random bursts
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder_tb;
  import u8u16_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 203;
  localparam int CALM_BYTES   = 40;
  localparam int DRAIN_CYCLES = 5000;
  localparam int TAIL_CYCLES  = 10;

  class transcode_checker;
    logic [20:0] acc_point;
    logic [1:0]  left_cnt;
    logic [1:0]  held_cnt;
    logic [15:0] step_units[$];
    out_item_t   pending_units[$];
    int          errors;
    int          units_seen;
    int          pairs_seen;
    int          reps_seen;

    function new();
      clear_seq();
      errors     = 0;
      units_seen = 0;
      pairs_seen = 0;
      reps_seen  = 0;
    endfunction

    function void clear_seq();
      acc_point = '0;
      left_cnt  = '0;
      held_cnt  = '0;
    endfunction

    function void push_unit(logic [15:0] u);
      step_units = {step_units, u};
      if (u == REPLACEMENT) reps_seen++;
    endfunction

    function void emit_point(logic [20:0] cp);
      logic [20:0] v;
      if (cp <= BMP_MAX) begin
        push_unit(cp[15:0]);
      end else if (cp <= MAX_POINT) begin
        v = cp - SUPP_BASE;
        push_unit(HIGH_SURR + {6'd0, v[19:10]});
        push_unit(LOW_SURR + {6'd0, v[9:0]});
        pairs_seen++;
      end else begin
        push_unit(REPLACEMENT);
      end
    endfunction

    function void open_lead(logic [7:0] b, logic eot);
      logic [1:0]  need;
      logic [20:0] bits;
      if (b < 8'h80) begin
        push_unit({8'h00, b});
        return;
      end else if ((b & 8'hE0) == 8'hC0) begin
        need = 2'd1;
        bits = {16'd0, b[4:0]};
      end else if ((b & 8'hF0) == 8'hE0) begin
        need = 2'd2;
        bits = {17'd0, b[3:0]};
      end else if ((b & 8'hF8) == 8'hF0) begin
        need = 2'd3;
        bits = {18'd0, b[2:0]};
      end else begin
        push_unit(REPLACEMENT);
        return;
      end
      if (eot) begin
        push_unit(REPLACEMENT);
        clear_seq();
        return;
      end
      acc_point = bits;
      left_cnt  = need;
      held_cnt  = 2'd1;
    endfunction

    // predicts the units one accepted byte causes
    function void take_byte(in_item_t req);
      logic [20:0] cp;
      int          n;
      out_item_t   item;
      step_units.delete();
      if (left_cnt == 2'd0) begin
        open_lead(req.byte_in, req.end_of_text);
      end else if (req.byte_in[7:6] == 2'b10) begin
        cp = {acc_point[14:0], req.byte_in[5:0]};
        if (left_cnt == 2'd1) begin
          clear_seq();
          emit_point(cp);
        end else if (req.end_of_text) begin
          n = int'(held_cnt) + 1;
          clear_seq();
          repeat (n) push_unit(REPLACEMENT);
        end else begin
          acc_point = cp;
          left_cnt  = left_cnt - 2'd1;
          held_cnt  = held_cnt + 2'd1;
        end
      end else begin
        n = int'(held_cnt);
        clear_seq();
        repeat (n) push_unit(REPLACEMENT);
        open_lead(req.byte_in, req.end_of_text);
      end
      if (req.end_of_text) clear_seq();
      foreach (step_units[i]) begin
        item.code_unit = step_units[i];
        item.last_unit = (i == step_units.size() - 1);
        pending_units = {pending_units, item};
      end
    endfunction

    function void check_unit(out_item_t got);
      out_item_t want;
      if (pending_units.size() == 0) begin
        $error("unexpected code unit %h", got.code_unit);
        errors++;
        return;
      end
      want = pending_units.pop_front();
      units_seen++;
      if (got.code_unit !== want.code_unit) begin
        $error("code_unit expected %h actual %h", want.code_unit, got.code_unit);
        errors++;
      end
      if (got.last_unit !== want.last_unit) begin
        $error("last_unit expected %b actual %b", want.last_unit, got.last_unit);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  transcode_checker sb = new();
  bit calm      = 1'b0;
  int sent      = 0;
  int stop_at   = 0;
  int stall_left = 0;

  utf8_to_utf16_transcoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_unit(out_data);
  end

  // receiver backpressure in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (calm || !rst_n) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int       gap;
    in_item_t req;
    calm = (stop_at > 0) && (sent >= stop_at - CALM_BYTES);
    gap  = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.byte_in     = b;
    req.end_of_text = eot;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.take_byte(req);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] make_lead(int len);
    case (len)
      1:       return 8'($urandom_range(0, 127));
      2:       return {3'b110, 5'($urandom_range(0, 31))};
      3:       return {4'b1110, 4'($urandom_range(0, 15))};
      default: return {5'b11110, 3'($urandom_range(0, 7))};
    endcase
  endfunction

  function automatic logic [7:0] make_cont();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  task automatic send_well_formed();
    int   len;
    logic eot;
    len = $urandom_range(1, 4);
    eot = ($urandom_range(0, 7) == 0);
    send_byte(make_lead(len), eot && len == 1);
    for (int k = 1; k < len; k++) send_byte(make_cont(), eot && k == len - 1);
  endtask

  // truncated sequence, closed by end of text or by a breaking byte
  task automatic send_broken();
    int         len;
    int         k;
    logic       ending;
    logic [7:0] b;
    len    = $urandom_range(2, 4);
    k      = $urandom_range(0, len - 2);
    ending = 1'($urandom_range(0, 1));
    send_byte(make_lead(len), ending && k == 0);
    for (int j = 0; j < k; j++) send_byte(make_cont(), ending && j == k - 1);
    if (!ending) begin
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      send_byte(b, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    int pick;
    int drain;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ascii extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // smallest two-byte point
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    // overlong form passes through
    send_byte(8'hE0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // surrogate point passes through
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    // largest point, surrogate pair
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // above the unicode range
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // bad leads
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);
    // bad continuation after three held bytes, breaking byte is a bad lead
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    // text ends inside a sequence
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    // multi-byte lead flagged as the end
    send_byte(8'hC3, 1'b1);

    stop_at = sent + RANDOM_BYTES;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) send_well_formed();
      else if (pick < 85) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      else send_broken();
    end
    in_valid <= 1'b0;

    drain = 0;
    while (sb.pending_units.size() != 0 && drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_units.size() != 0) begin
      $error("%0d code units never arrived", sb.pending_units.size());
      sb.errors++;
    end

    $display("summary: %0d bytes in, %0d code units checked", sent, sb.units_seen);
    $display("summary: %0d surrogate pairs, %0d replacement units", sb.pairs_seen,
             sb.reps_seen);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: utf8_to_utf16_transcoder.f
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_fifo.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_transcoder.sv
sim/utf8_to_utf16_transcoder_tb.sv
